[sv/top_n_score_tracker_macros.svh]
// Assertion macros for the top-N score tracker.
`ifndef TOP_N_SCORE_TRACKER_MACROS_SVH
`define TOP_N_SCORE_TRACKER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define TNST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnst assertion failed");
// next-cycle implication
`define TNST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnst assertion failed");
`else
`define TNST_ASSERT_NOW(label, ante, cons)
`define TNST_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[sv/tnst_pkg.sv]
// Shared types and constants for the top-N score tracker.
package tnst_pkg;

  localparam int unsigned MaxOut = 16;

  localparam logic signed [31:0] MinScoreNone = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_DUMP  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FINISH,
    S_DUMP
  } state_t;

  // broadcast from the control to every cell
  typedef struct packed {
    logic               offer;
    logic               clear;
    logic [31:0]        item_id;
    logic signed [31:0] score;
  } cell_ctrl_t;

  typedef struct packed {
    logic               valid;
    logic [31:0]        item_id;
    logic signed [31:0] score;
  } entry_t;

endpackage

[sv/tnst_cell.sv]
// One slot of the sorted table: compares against the offer and shifts down.
module tnst_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  tnst_pkg::cell_ctrl_t ctrl,
  input  logic                in_range,
  input  logic                beaten_in,
  input  tnst_pkg::entry_t    prev,
  output tnst_pkg::entry_t    entry,
  output logic                beaten_out,
  output logic                insert
);

  logic               valid_r;
  logic [31:0]        id_r;
  logic signed [31:0] score_r;
  logic               beats;
  logic               shift;

  // empty slot takes anything; ties on score go to the smaller id, and to the offer on equal ids
  assign beats = !valid_r || (ctrl.score > score_r) ||
                 ((ctrl.score == score_r) && (ctrl.item_id <= id_r));

  assign insert     = in_range && beats && !beaten_in;
  assign shift      = in_range && beaten_in;
  assign beaten_out = beaten_in || (in_range && beats);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctrl.clear) begin
      valid_r <= 1'b0;
    end else if (ctrl.offer && insert) begin
      valid_r <= 1'b1;
    end else if (ctrl.offer && shift) begin
      valid_r <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.offer && insert) begin
      id_r    <= ctrl.item_id;
      score_r <= ctrl.score;
    end else if (ctrl.offer && shift) begin
      id_r    <= prev.item_id;
      score_r <= prev.score;
    end
  end

  assign entry.valid   = valid_r;
  assign entry.item_id = id_r;
  assign entry.score   = score_r;

endmodule

[sv/top_n_score_tracker.sv]
// Top level of the top-N score tracker: cell chain, sequencer and output register.
//
//  channel | dir | payload
//  in_     | in  | opcode, item_id, score
//  out_    | out | accepted, slot_index, slot_id, slot_score, slot_valid, min_score, last
//  cfg_    | in  | slots_in_use (write only)
//
// Offer, clear and no-op: one result, registered; no new item is taken until it loads.
// Dump: n results, one slot read a cycle through the output register unless stalled.
// Offer compare and shift happen in every in-range cell in the transfer cycle.
// Reset is synchronous; it empties the table and sets slots_in_use to 10.
// out_ready low holds the sequencer; in_ready is high only between items.
`include "top_n_score_tracker_macros.svh"

module top_n_score_tracker #(
  parameter int unsigned SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [31:0]        in_item_id,
  input  logic signed [31:0] in_score,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_accepted,
  output logic [3:0]         out_slot_index,
  output logic [31:0]        out_slot_id,
  output logic signed [31:0] out_slot_score,
  output logic               out_slot_valid,
  output logic signed [31:0] out_min_score,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data
);

  localparam int unsigned NMax = (SLOTS < tnst_pkg::MaxOut) ? SLOTS : tnst_pkg::MaxOut;

  tnst_pkg::state_t     state_r, state_nxt;
  tnst_pkg::op_t        op;
  tnst_pkg::cell_ctrl_t ctrl;
  tnst_pkg::entry_t     cells [SLOTS];
  tnst_pkg::entry_t     prev_entry [SLOTS];
  tnst_pkg::entry_t     dump_sel;
  tnst_pkg::entry_t     tail_sel;

  logic [4:0]         slots_r;
  logic [4:0]         n_act;
  logic [3:0]         last_idx;
  logic [SLOTS:0]     beaten;
  logic [SLOTS-1:0]   ins;
  logic [SLOTS-1:0]   in_range;
  logic               in_fire;
  logic               out_load;
  logic               dump_last;
  logic [3:0]         pos;
  logic signed [31:0] min_now;

  logic               pend_acc_r, pend_acc_nxt;
  logic [3:0]         pend_pos_r, pend_pos_nxt;
  logic [3:0]         dump_cnt_r, dump_cnt_nxt;

  logic               out_valid_r;
  logic               out_accepted_r;
  logic [3:0]         out_slot_index_r;
  logic [31:0]        out_slot_id_r;
  logic signed [31:0] out_slot_score_r;
  logic               out_slot_valid_r;
  logic signed [31:0] out_min_score_r;
  logic               out_last_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r <= 5'd10;
    end else if (cfg_wr_en) begin
      slots_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (slots_r == 5'd0) begin
      n_act = 5'd1;
    end else if (slots_r > 5'(NMax)) begin
      n_act = 5'(NMax);
    end else begin
      n_act = slots_r;
    end
  end

  assign last_idx = 4'(n_act - 5'd1);

  // cell chain
  assign op           = tnst_pkg::op_t'(in_opcode);
  assign in_fire      = in_valid && in_ready;
  assign ctrl.offer   = in_fire && (op == tnst_pkg::OP_OFFER);
  assign ctrl.clear   = in_fire && (op == tnst_pkg::OP_CLEAR);
  assign ctrl.item_id = in_item_id;
  assign ctrl.score   = in_score;
  assign beaten[0]    = 1'b0;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    if (i < NMax) begin : g_live
      assign in_range[i] = 5'(i) < n_act;
    end else begin : g_idle
      assign in_range[i] = 1'b0;
    end

    if (i == 0) begin : g_head
      assign prev_entry[i] = '0;
    end else begin : g_link
      assign prev_entry[i] = cells[i-1];
    end

    tnst_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .in_range   (in_range[i]),
      .beaten_in  (beaten[i]),
      .prev       (prev_entry[i]),
      .entry      (cells[i]),
      .beaten_out (beaten[i+1]),
      .insert     (ins[i])
    );
  end

  // insert position, dump read and tail read
  always_comb begin
    pos      = '0;
    dump_sel = '0;
    tail_sel = '0;
    for (int i = 0; i < NMax; i++) begin
      if (ins[i]) begin
        pos = pos | 4'(i);
      end
      if (dump_cnt_r == 4'(i)) begin
        dump_sel = cells[i];
      end
      if (last_idx == 4'(i)) begin
        tail_sel = cells[i];
      end
    end
  end

  assign min_now   = tail_sel.valid ? tail_sel.score : tnst_pkg::MinScoreNone;
  assign dump_last = dump_cnt_r == last_idx;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tnst_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tnst_pkg::S_IDLE: begin
        if (in_fire) begin
          state_nxt = (op == tnst_pkg::OP_DUMP) ? tnst_pkg::S_DUMP : tnst_pkg::S_FINISH;
        end
      end
      tnst_pkg::S_FINISH: begin
        if (out_load) begin
          state_nxt = tnst_pkg::S_IDLE;
        end
      end
      tnst_pkg::S_DUMP: begin
        if (out_load && dump_last) begin
          state_nxt = tnst_pkg::S_IDLE;
        end
      end
      default: state_nxt = tnst_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    out_load     = 1'b0;
    pend_acc_nxt = pend_acc_r;
    pend_pos_nxt = pend_pos_r;
    dump_cnt_nxt = dump_cnt_r;
    unique case (state_r)
      tnst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          pend_acc_nxt = ctrl.offer && (|ins);
          pend_pos_nxt = ctrl.offer ? pos : 4'd0;
          dump_cnt_nxt = 4'd0;
        end
      end
      tnst_pkg::S_FINISH: begin
        out_load = !out_valid_r || out_ready;
      end
      tnst_pkg::S_DUMP: begin
        out_load = !out_valid_r || out_ready;
        if (out_load) begin
          dump_cnt_nxt = dump_cnt_r + 4'd1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pend_acc_r <= pend_acc_nxt;
    pend_pos_r <= pend_pos_nxt;
    dump_cnt_r <= dump_cnt_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_score_r <= min_now;
      if (state_r == tnst_pkg::S_DUMP) begin
        out_accepted_r   <= 1'b0;
        out_slot_index_r <= dump_cnt_r;
        out_slot_id_r    <= dump_sel.valid ? dump_sel.item_id : 32'd0;
        out_slot_score_r <= dump_sel.valid ? dump_sel.score : 32'sd0;
        out_slot_valid_r <= dump_sel.valid;
        out_last_r       <= dump_last;
      end else begin
        out_accepted_r   <= pend_acc_r;
        out_slot_index_r <= pend_pos_r;
        out_slot_id_r    <= 32'd0;
        out_slot_score_r <= 32'sd0;
        out_slot_valid_r <= 1'b0;
        out_last_r       <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_slot_index = out_slot_index_r;
  assign out_slot_id    = out_slot_id_r;
  assign out_slot_score = out_slot_score_r;
  assign out_slot_valid = out_slot_valid_r;
  assign out_min_score  = out_min_score_r;
  assign out_last       = out_last_r;

  `TNST_ASSERT_NOW(a_one_insert, 1'b1, $onehot0(ins))
  `TNST_ASSERT_NEXT(a_accept_flag, ctrl.offer && (|ins), pend_acc_r)
  `TNST_ASSERT_NEXT(a_dump_end,
      (state_r == tnst_pkg::S_DUMP) && out_load && dump_last,
      out_valid && out_last && (state_r == tnst_pkg::S_IDLE))
  `TNST_ASSERT_NEXT(a_busy_after, in_fire, !in_ready)

endmodule

[bench/top_n_score_tracker_tb.sv]
// Self-checking testbench for the top-N score tracker: directed table, then random offers, dumps, no-ops and clears.
module top_n_score_tracker_tb;

  localparam int Slots = 16;
  localparam int DirRows = 23;
  localparam int SegItems = 52;

  typedef struct packed {
    logic               accepted;
    logic [3:0]         slot_index;
    logic [31:0]        slot_id;
    logic signed [31:0] slot_score;
    logic               slot_valid;
    logic signed [31:0] min_score;
    logic               last;
  } slot_result_t;

  // one line of the directed script: either a register write or an item,
  // with an optional hand-written result for single-result items
  typedef struct packed {
    logic               is_cfg;
    logic [4:0]         cfg_val;
    tnst_pkg::op_t      op;
    logic [31:0]        id;
    logic signed [31:0] sc;
    logic               typed;
    logic               t_acc;
    logic [3:0]         t_idx;
    logic signed [31:0] t_min;
  } script_row_t;

  localparam logic signed [31:0] ScoreMax = 32'sh7FFF_FFFF;

  localparam script_row_t Script [DirRows] = '{
    '{1'b0, 5'd0, tnst_pkg::OP_NOP, 32'd0, 32'sd0, 1'b1, 1'b0, 4'd0, tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_DUMP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd5, 32'sd100, 1'b1, 1'b1, 4'd0, tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'hFFFF_FFFF, ScoreMax, 1'b1, 1'b1, 4'd0,
      tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd0, tnst_pkg::MinScoreNone, 1'b1, 1'b1, 4'd2,
      tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd0, ScoreMax, 1'b1, 1'b1, 4'd0, tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd0, ScoreMax, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd7, 32'sd100, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd5, 32'sd100, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd3, -32'sd1, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_DUMP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b1, 5'd1, tnst_pkg::OP_NOP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd9, -32'sd5, 1'b1, 1'b0, 4'd0, ScoreMax},
    '{1'b0, 5'd0, tnst_pkg::OP_DUMP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b1, 5'd0, tnst_pkg::OP_NOP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'd1, ScoreMax, 1'b1, 1'b0, 4'd0, ScoreMax},
    '{1'b1, 5'd31, tnst_pkg::OP_NOP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_DUMP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_CLEAR, 32'hFFFF_FFFF, -32'sd1, 1'b1, 1'b0, 4'd0,
      tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_DUMP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b1, 5'd16, tnst_pkg::OP_NOP, 32'd0, 32'sd0, 1'b0, 1'b0, 4'd0, 32'sd0},
    '{1'b0, 5'd0, tnst_pkg::OP_OFFER, 32'hA5A5_A5A5, 32'sh5A5A_5A5A, 1'b1, 1'b1, 4'd0,
      tnst_pkg::MinScoreNone},
    '{1'b0, 5'd0, tnst_pkg::OP_NOP, 32'd0, 32'sd0, 1'b1, 1'b0, 4'd0, tnst_pkg::MinScoreNone}
  };

  localparam logic [4:0] SegSlots [8] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd10, 5'd2, 5'd13};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_opcode = 2'd0;
  logic [31:0]        in_item_id = 32'd0;
  logic signed [31:0] in_score = 32'sd0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_accepted;
  logic [3:0]         out_slot_index;
  logic [31:0]        out_slot_id;
  logic signed [31:0] out_slot_score;
  logic               out_slot_valid;
  logic signed [31:0] out_min_score;
  logic               out_last;
  logic               cfg_wr_en = 1'b0;
  logic [4:0]         cfg_wr_data = 5'd0;

  // predicted table and register
  logic [4:0]         slots_reg = 5'd10;
  logic [31:0]        tab_id [Slots];
  logic signed [31:0] tab_score [Slots];
  logic               tab_valid [Slots] = '{default: 1'b0};

  slot_result_t results_due [$];
  slot_result_t head_result;
  int           mismatches = 0;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit send_calm = 1'b0;
  int recv_calm_left = 0;

  top_n_score_tracker #(.SLOTS(Slots)) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_item_id     (in_item_id),
    .in_score       (in_score),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_accepted   (out_accepted),
    .out_slot_index (out_slot_index),
    .out_slot_id    (out_slot_id),
    .out_slot_score (out_slot_score),
    .out_slot_valid (out_slot_valid),
    .out_min_score  (out_min_score),
    .out_last       (out_last),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one transferred item to the predicted table and queue its results.
  function automatic void rank_item(input tnst_pkg::op_t op, input logic [31:0] id,
                                    input logic signed [31:0] sc);
    int n;
    int pos;
    bit found;
    slot_result_t r;
    n = (slots_reg == 5'd0) ? 1 : ((slots_reg > 5'd16) ? Slots : int'(slots_reg));
    r = '0;
    r.last = 1'b1;
    case (op)
      tnst_pkg::OP_OFFER: begin
        found = 1'b0;
        pos = 0;
        for (int i = 0; i < n; i++) begin
          if (!found && (!tab_valid[i] || sc > tab_score[i] ||
                         (sc == tab_score[i] && id <= tab_id[i]))) begin
            found = 1'b1;
            pos = i;
          end
        end
        if (found) begin
          for (int j = n - 1; j > pos; j--) begin
            tab_id[j] = tab_id[j - 1];
            tab_score[j] = tab_score[j - 1];
            tab_valid[j] = tab_valid[j - 1];
          end
          tab_id[pos] = id;
          tab_score[pos] = sc;
          tab_valid[pos] = 1'b1;
        end
        r.accepted = found;
        r.slot_index = pos[3:0];
        r.min_score = tab_valid[n - 1] ? tab_score[n - 1] : tnst_pkg::MinScoreNone;
        results_due.push_back(r);
      end
      tnst_pkg::OP_DUMP: begin
        r.min_score = tab_valid[n - 1] ? tab_score[n - 1] : tnst_pkg::MinScoreNone;
        for (int i = 0; i < n; i++) begin
          r.slot_index = i[3:0];
          r.slot_valid = tab_valid[i];
          r.slot_id = tab_valid[i] ? tab_id[i] : 32'd0;
          r.slot_score = tab_valid[i] ? tab_score[i] : 32'sd0;
          r.last = (i == n - 1);
          results_due.push_back(r);
        end
      end
      default: begin
        if (op == tnst_pkg::OP_CLEAR) begin
          for (int i = 0; i < Slots; i++) tab_valid[i] = 1'b0;
        end
        r.min_score = tab_valid[n - 1] ? tab_score[n - 1] : tnst_pkg::MinScoreNone;
        results_due.push_back(r);
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input tnst_pkg::op_t op, input logic [31:0] id,
                           input logic signed [31:0] sc,
                           input bit typed, input slot_result_t typed_res);
    while (!send_calm && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_item_id <= id;
    in_score <= sc;
    do @(posedge clk); while (!in_ready);
    rank_item(op, id, sc);
    if (typed) results_due[$] = typed_res;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_slots(input logic [4:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    slots_reg = v;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stalls with occasional calm stretches
  always @(negedge clk) begin
    if (recv_calm_left > 0) recv_calm_left <= recv_calm_left - 1;
    else if ($urandom_range(99) == 0) recv_calm_left <= $urandom_range(60, 20);
    out_ready <= (recv_calm_left > 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing outstanding");
        mismatches++;
      end else begin
        head_result = results_due.pop_front();
        check_field("accepted", 32'(head_result.accepted), 32'(out_accepted));
        check_field("slot_index", 32'(head_result.slot_index), 32'(out_slot_index));
        check_field("slot_id", head_result.slot_id, out_slot_id);
        check_field("slot_score", head_result.slot_score, out_slot_score);
        check_field("slot_valid", 32'(head_result.slot_valid), 32'(out_slot_valid));
        check_field("min_score", head_result.min_score, out_min_score);
        check_field("last", 32'(head_result.last), 32'(out_last));
      end
    end
  end

  initial begin
    tnst_pkg::op_t op;
    logic [31:0] id;
    logic signed [31:0] sc;
    int pick;
    slot_result_t typed_res;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int k = 0; k < DirRows; k++) begin
      if (Script[k].is_cfg) begin
        drain_results();
        load_slots(Script[k].cfg_val);
      end else begin
        typed_res = '0;
        typed_res.accepted = Script[k].t_acc;
        typed_res.slot_index = Script[k].t_idx;
        typed_res.min_score = Script[k].t_min;
        typed_res.last = 1'b1;
        send_item(Script[k].op, Script[k].id, Script[k].sc, Script[k].typed, typed_res);
      end
    end

    for (int seg = 0; seg < 8; seg++) begin
      drain_results();
      load_slots(SegSlots[seg]);
      case (seg % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int k = 0; k < SegItems; k++) begin
        if (k % 16 == 0) send_calm = ($urandom_range(3) == 0);
        pick = $urandom_range(99);
        if (pick < 78) op = tnst_pkg::OP_OFFER;
        else if (pick < 90) op = tnst_pkg::OP_DUMP;
        else if (pick < 97) op = tnst_pkg::OP_NOP;
        else op = tnst_pkg::OP_CLEAR;
        // small id and score ranges make ties and rejections common
        pick = $urandom_range(19);
        if (pick < 10) id = $urandom_range(7);
        else if (pick < 17) id = $urandom;
        else id = $urandom_range(1) ? 32'hFFFF_FFFF : 32'd0;
        pick = $urandom_range(9);
        if (pick < 5) sc = $signed($urandom_range(12)) - 6;
        else if (pick < 8) sc = $urandom;
        else begin
          case ($urandom_range(3))
            0: sc = tnst_pkg::MinScoreNone;
            1: sc = ScoreMax;
            2: sc = 32'sd0;
            default: sc = -32'sd1;
          endcase
        end
        send_item(op, id, sc, 1'b0, '0);
      end
    end

    drain_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
